/* hw/rtl/u64_key_hash_map_unit_macros.svh */
// Assertion macros used by the hash map top module u64_key_hash_map_unit.
// Needs signals clk and rst in the including module.
`ifndef U64_KEY_HASH_MAP_UNIT_MACROS_SVH
`define U64_KEY_HASH_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define U64HM_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define U64HM_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/u64hm_pkg.sv */
// Package for the 64-bit key hash map: opcodes, status codes, FSM states, mix constants.
// No dependencies.
`default_nettype none
package u64hm_pkg;

  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;
  localparam int unsigned OCC_W     = 11;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_WALK,
    ST_CHK,
    ST_ACT,
    ST_POP,
    ST_REM2,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/u64hm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module u64hm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/u64hm_mix.sv */
// fmix64 key mixer on one shared 32x32 multiplier; a start abandons any key in progress.
// Depends on u64hm_pkg.
`default_nettype none
module u64hm_mix #(
  parameter int unsigned BW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   key,
  output logic               done,
  output logic [BW-1:0]      bucket
);
  import u64hm_pkg::*;

  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [63:0] cst;
  logic [63:0] sum;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [1:0]  step;
  logic        pass;
  logic        run;

  // Pick the constant of this pass and the partial product of this step
  assign cst = pass ? MIX_C2 : MIX_C1;
  always_comb begin
    case (step)
      2'd0:    begin op_a = x[31:0];  op_b = cst[31:0];  end
      2'd1:    begin op_a = x[63:32]; op_b = cst[31:0];  end
      default: begin op_a = x[31:0];  op_b = cst[63:32]; end
    endcase
  end

  // Add a cross product into the upper half of the low 64 bits
  assign sum = acc + {prod[31:0], 32'd0};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
      pass <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= 2'd0;
        pass <= 1'b0;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          if (pass) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            pass <= 1'b1;
          end
        end
      end
    end
  end

  // Multiply and accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      x <= key ^ (key >> MIX_SHIFT);
    end else if (run) begin
      prod <= op_a * op_b;
      case (step)
        2'd1:    acc <= prod;
        2'd2:    acc <= sum;
        2'd3:    x   <= sum ^ (sum >> MIX_SHIFT);
        default: ;
      endcase
    end
  end

  assign bucket = x[BW-1:0];

endmodule
`default_nettype wire

/* hw/rtl/u64_key_hash_map_unit.sv */
// Chained hash map, 64-bit keys to 64-bit values: find, insert or update, remove.
// One request at a time: the key is hashed, the bucket head is read, each chain entry visited is read
// and compared against the key, then the write-back states run and the result goes to the output,
// which out_stall can hold. The next request is taken in the cycle after the result is loaded,
// while that result may still wait in the output.
// After reset the bucket heads are cleared one per cycle, all BUCKETS of them, with in_stall high.
`default_nettype none
module u64_key_hash_map_unit #(
  parameter int unsigned BUCKETS = 1024,
  parameter int unsigned ENTRIES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    opcode,
  input  wire logic [63:0]                   lookup_key,
  input  wire logic [63:0]                   new_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [63:0]                        found_value,
  output logic [u64hm_pkg::OCC_W-1:0]        occupancy
);
  import u64hm_pkg::*;
  `include "u64_key_hash_map_unit_macros.svh"

  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned EAW   = $clog2(ENTRIES);
  localparam int unsigned LW    = EAW + 1;
  localparam int unsigned CW    = $clog2(ENTRIES + 1);
  localparam int unsigned ENT_W = 128 + LW;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  state_t state, state_next;

  // Request and walk registers
  logic [1:0]       op_q;
  logic [63:0]      key_q;
  logic [63:0]      val_q;
  logic [BW-1:0]    b_q;
  logic [LW-1:0]    head_q;
  logic [LW-1:0]    cur;
  logic [LW-1:0]    prev;
  logic [63:0]      prev_key;
  logic [63:0]      prev_val;
  logic [63:0]      cur_val;
  logic [LW-1:0]    cur_link;
  logic             found;
  logic [CW-1:0]    steps;
  logic [1:0]       res_status;
  logic [63:0]      res_fv;

  // Pool bookkeeping
  logic [LW-1:0]    free_head;
  logic [CW-1:0]    fresh;
  logic [CW-1:0]    count;
  logic [BW-1:0]    clr_idx;
  logic [63:0]      cnt_wide;

  // Mixer
  logic             mix_start;
  logic             mix_done;
  logic [BW-1:0]    mix_bucket;

  // Memory ports
  logic             bkt_we;
  logic [BW-1:0]    bkt_waddr;
  logic [LW-1:0]    bkt_wdata;
  logic [BW-1:0]    bkt_raddr;
  logic [LW-1:0]    bkt_rd;
  logic             ent_we;
  logic [EAW-1:0]   ent_waddr;
  logic [ENT_W-1:0] ent_wdata;
  logic [EAW-1:0]   ent_raddr;
  logic [ENT_W-1:0] ent_rd;
  logic [63:0]      rd_key;
  logic [63:0]      rd_val;
  logic [LW-1:0]    rd_link;

  logic in_xfer;
  logic out_load;
  logic free_ok;
  logic fresh_ok;
  logic at_nil;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  assign free_ok  = (free_head != NIL);
  assign fresh_ok = (fresh != CW'(ENTRIES));
  assign at_nil   = (cur == NIL) || (steps == CW'(ENTRIES));
  assign mix_start = in_xfer;

  assign rd_key  = ent_rd[ENT_W-1 -: 64];
  assign rd_val  = ent_rd[LW +: 64];
  assign rd_link = ent_rd[LW-1:0];

  u64hm_mix #(.BW(BW)) u_mix (
    .clk    (clk),
    .rst    (rst),
    .start  (mix_start),
    .key    (lookup_key),
    .done   (mix_done),
    .bucket (mix_bucket)
  );

  u64hm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rd)
  );

  u64hm_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == BW'(BUCKETS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_next = ST_HASH;
      ST_HASH:  if (mix_done) state_next = ST_HEAD;
      ST_HEAD:  state_next = ST_WALK;
      ST_WALK:  state_next = at_nil ? ST_ACT : ST_CHK;
      ST_CHK:   state_next = (rd_key == key_q) ? ST_ACT : ST_WALK;
      ST_ACT: begin
        if (op_q == OP_INSERT && !found && free_ok) begin
          state_next = ST_POP;
        end else if (op_q == OP_REMOVE && found) begin
          state_next = ST_REM2;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_POP:   state_next = ST_DONE;
      ST_REM2:  state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Memory controls
  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = b_q;
    bkt_wdata = NIL;
    bkt_raddr = mix_bucket;
    ent_we    = 1'b0;
    ent_waddr = cur[EAW-1:0];
    ent_wdata = {key_q, val_q, cur_link};
    ent_raddr = cur[EAW-1:0];
    unique case (state)
      ST_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_idx;
      end
      ST_ACT: begin
        if (op_q == OP_INSERT) begin
          if (found) begin
            ent_we = 1'b1;
          end else if (free_ok) begin
            ent_raddr = free_head[EAW-1:0];
          end else if (fresh_ok) begin
            ent_we    = 1'b1;
            ent_waddr = fresh[EAW-1:0];
            ent_wdata = {key_q, val_q, head_q};
            bkt_we    = 1'b1;
            bkt_wdata = LW'(fresh);
          end
        end else if (op_q == OP_REMOVE && found) begin
          if (prev != NIL) begin
            ent_we    = 1'b1;
            ent_waddr = prev[EAW-1:0];
            ent_wdata = {prev_key, prev_val, cur_link};
          end else begin
            bkt_we    = 1'b1;
            bkt_wdata = cur_link;
          end
        end
      end
      ST_POP: begin
        ent_we    = 1'b1;
        ent_waddr = free_head[EAW-1:0];
        ent_wdata = {key_q, val_q, head_q};
        bkt_we    = 1'b1;
        bkt_wdata = free_head;
      end
      ST_REM2: begin
        ent_we    = 1'b1;
        ent_wdata = {key_q, cur_val, free_head};
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + BW'(1);
      end
      if (state == ST_ACT && op_q == OP_INSERT && !found && !free_ok && fresh_ok) begin
        fresh <= fresh + CW'(1);
        count <= count + CW'(1);
      end
      if (state == ST_POP) begin
        free_head <= rd_link;
        count     <= count + CW'(1);
      end
      if (state == ST_REM2) begin
        free_head <= cur;
        if (count != '0) begin
          count <= count - CW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cnt_wide = 64'(count);

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_q  <= opcode;
        key_q <= lookup_key;
        val_q <= new_value;
      end
      ST_HASH: b_q <= mix_bucket;
      ST_HEAD: begin
        head_q <= bkt_rd;
        cur    <= bkt_rd;
        prev   <= NIL;
        steps  <= '0;
        found  <= 1'b0;
      end
      ST_CHK: begin
        if (rd_key == key_q) begin
          found    <= 1'b1;
          cur_val  <= rd_val;
          cur_link <= rd_link;
        end else begin
          prev     <= cur;
          prev_key <= rd_key;
          prev_val <= rd_val;
          cur      <= rd_link;
          steps    <= steps + CW'(1);
        end
      end
      ST_ACT: begin
        res_fv     <= '0;
        res_status <= found ? STAT_OK : STAT_NOT_FOUND;
        case (op_q)
          OP_INSERT: begin
            if (!found && !free_ok && !fresh_ok) begin
              res_status <= STAT_FULL;
            end else begin
              res_status <= STAT_OK;
            end
          end
          OP_REMOVE: ;
          default: begin
            if (found) begin
              res_fv <= cur_val;
            end
          end
        endcase
      end
      ST_DONE: begin
        if (out_load) begin
          status      <= res_status;
          found_value <= res_fv;
          occupancy   <= cnt_wide[OCC_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Checks
  `U64HM_CHECK(a_count_range, 1'b1, count <= CW'(ENTRIES), "stored count above pool size")
  `U64HM_CHECK(a_mix_in_hash, mix_done, state == ST_HASH, "mixer finished outside hashing")
  `U64HM_CHECK(a_no_bkt_wr_walk, state == ST_WALK || state == ST_CHK, !bkt_we, "bucket write during walk")
  `U64HM_NEXT(a_free_push, state == ST_REM2, free_head == $past(cur), "removed entry not pushed on free chain")

endmodule
`default_nettype wire
